FILE: rtl/core/scspa_pkg.sv
// shared types and constants of the size class slot pool allocator
package scspa_pkg;

	localparam int NUM_CLASSES_DEF     = 3;
	localparam int SLOTS_PER_CLASS_DEF = 32;

	localparam int NUM_CFG_REGS = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 6;
	localparam int CLS_FIELD_W  = 2;
	localparam int HANDLE_W     = 7;
	localparam int STATUS_W     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_CLASS0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_CLASS1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_CLASS2 = 2'd2;

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic [CFG_DATA_W-1:0] SLOTS_RESET = 6'd32;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED   = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_RELEASED  = 3'd2,
		ST_NULL      = 3'd3,
		ST_OUTSIDE   = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

endpackage

FILE: rtl/core/size_class_slot_pool_allocator_unit.sv
// top level of the size class slot pool allocator
// the request register loads when the input transaction is accepted; the result register
//   loads in the execute step, once the output register is free or is being emptied
// a new request is not taken until the previous one has executed, set by the capture and
//   execute steps of the controller around the single bitmap read-modify-write
// a new request is taken while a finished result still waits in the output register
// reset: all slots free, every slot count at 32, no result pending
module size_class_slot_pool_allocator_unit #(
	parameter int NUM_CLASSES     = scspa_pkg::NUM_CLASSES_DEF,
	parameter int SLOTS_PER_CLASS = scspa_pkg::SLOTS_PER_CLASS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // handle[6:0], zero pad
	input  logic [3:0]                       s_tuser,  // action, size_class[1:0], handle_present
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,  // granted_handle[6:0], zero pad
	output logic [2:0]                       m_tuser,  // status[2:0]
	// configuration writes
	input  logic                             cfg_we,
	input  logic [scspa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scspa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import scspa_pkg::*;

	dp_cmd_t             cmd;
	logic [STATUS_W-1:0] res_status;
	logic [HANDLE_W-1:0] res_granted_handle;

	// controller: accepts a transaction, then executes when the output register frees up
	scspa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// datapath: handle decode, lowest free slot search, bitmap update
	scspa_dp #(
		.NUM_CLASSES     (NUM_CLASSES),
		.SLOTS_PER_CLASS (SLOTS_PER_CLASS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.req_action         (s_tuser[0]),
		.req_size_class     (s_tuser[2:1]),
		.req_handle_present (s_tuser[3]),
		.req_handle         (s_tdata[HANDLE_W-1:0]),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.res_status         (res_status),
		.res_granted_handle (res_granted_handle)
	);

	// pack the result transaction
	assign m_tdata = {1'b0, res_granted_handle};
	assign m_tuser = res_status;

endmodule

FILE: rtl/core/scspa_ctrl.sv
// handshake controller of the pool allocator
module scspa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output scspa_pkg::dp_cmd_t cmd
);
	import scspa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        can_load;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	// output register is free now or is emptied this cycle
	assign can_load = !out_valid_q || m_tready;

	always_comb begin
		state_nxt   = state_q;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (can_load) begin
					cmd.execute = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/scspa_dp.sv
// datapath: request register, slot counts, in-use bitmaps, result register
module scspa_dp #(
	parameter int NUM_CLASSES     = scspa_pkg::NUM_CLASSES_DEF,
	parameter int SLOTS_PER_CLASS = scspa_pkg::SLOTS_PER_CLASS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  scspa_pkg::dp_cmd_t                  cmd,
	input  logic                                req_action,
	input  logic [scspa_pkg::CLS_FIELD_W-1:0]   req_size_class,
	input  logic                                req_handle_present,
	input  logic [scspa_pkg::HANDLE_W-1:0]      req_handle,
	input  logic                                cfg_we,
	input  logic [scspa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scspa_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [scspa_pkg::STATUS_W-1:0]      res_status,
	output logic [scspa_pkg::HANDLE_W-1:0]      res_granted_handle
);
	import scspa_pkg::*;

	localparam int SLOT_W = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam logic [CFG_DATA_W-1:0] SLOTS_MAX = CFG_DATA_W'(SLOTS_PER_CLASS);
	localparam logic [HANDLE_W:0] POOL_END = (HANDLE_W + 1)'(NUM_CLASSES * SLOTS_PER_CLASS);

	// captured request
	logic                   act_q;
	logic [CLS_FIELD_W-1:0] cls_req_q;
	logic                   present_q;
	logic [HANDLE_W-1:0]    handle_q;

	logic [CFG_DATA_W-1:0]      cnt_q [NUM_CFG_REGS];
	logic [SLOTS_PER_CLASS-1:0] map_q [NUM_CLASSES];

	logic [STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0] granted_q;

	logic [CLS_W-1:0]           hcls;
	logic [HANDLE_W:0]          hrem;
	logic [SLOT_W-1:0]          hslot;
	logic                       outside;
	logic                       cls_ok;
	logic [CLS_W-1:0]           addr;
	logic                       addr_ok;
	logic [SLOTS_PER_CLASS-1:0] sel_map;
	logic [CFG_DATA_W-1:0]      sel_cnt;
	logic [CFG_DATA_W-1:0]      eff_cnt;
	logic [SLOTS_PER_CLASS-1:0] usable;
	logic [SLOTS_PER_CLASS-1:0] free_bits;
	logic [SLOTS_PER_CLASS-1:0] lowest;
	logic [SLOT_W-1:0]          free_idx;
	logic [SLOTS_PER_CLASS-1:0] slot_dec;
	logic [HANDLE_W-1:0]        alloc_base;
	logic                       slot_ok;
	status_t                    status_nxt;
	logic [HANDLE_W-1:0]        granted_nxt;
	logic [SLOTS_PER_CLASS-1:0] map_nxt;
	logic                       map_we;

	// handle split into class and slot by compares against class bases
	always_comb begin
		hcls = '0;
		hrem = {1'b0, handle_q};
		for (int k = 0; k < NUM_CLASSES; k++) begin
			if ({1'b0, handle_q} >= (HANDLE_W + 1)'(k * SLOTS_PER_CLASS)) begin
				hcls = CLS_W'(k);
				hrem = {1'b0, handle_q} - (HANDLE_W + 1)'(k * SLOTS_PER_CLASS);
			end
		end
	end

	assign hslot   = hrem[SLOT_W-1:0];
	assign outside = ({1'b0, handle_q} >= POOL_END);
	assign cls_ok  = (32'(cls_req_q) < NUM_CLASSES);
	assign addr    = act_q ? hcls : CLS_W'(cls_req_q);
	assign addr_ok = act_q ? !outside : cls_ok;
	assign sel_map = addr_ok ? map_q[addr] : '0;
	assign sel_cnt = addr_ok ? cnt_q[addr] : '0;
	assign eff_cnt = (sel_cnt > SLOTS_MAX) ? SLOTS_MAX : sel_cnt;
	assign alloc_base = HANDLE_W'(32'(cls_req_q) * SLOTS_PER_CLASS);

	always_comb begin
		for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
			usable[i]   = (CFG_DATA_W'(i) < eff_cnt);
			slot_dec[i] = (hslot == SLOT_W'(i));
		end
	end

	assign free_bits = ~sel_map & usable;
	assign lowest    = free_bits & (~free_bits + 1'b1);

	// encode the one-hot lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
			if (lowest[i]) begin
				free_idx = free_idx | SLOT_W'(i);
			end
		end
	end

	assign slot_ok = (CFG_DATA_W'(hslot) < eff_cnt) && sel_map[hslot];

	always_comb begin
		status_nxt  = ST_EMPTY;
		granted_nxt = '0;
		map_nxt     = sel_map;
		map_we      = 1'b0;
		if (act_q == ACT_ALLOC) begin
			if (cls_ok && (free_bits != '0)) begin
				status_nxt  = ST_GRANTED;
				granted_nxt = alloc_base + HANDLE_W'(free_idx);
				map_nxt     = sel_map | lowest;
				map_we      = 1'b1;
			end
		end else if (!present_q) begin
			status_nxt = ST_NULL;
		end else if (outside) begin
			status_nxt = ST_OUTSIDE;
		end else if (!slot_ok) begin
			status_nxt = ST_NOT_FOUND;
		end else begin
			status_nxt = ST_RELEASED;
			map_nxt    = sel_map & ~slot_dec;
			map_we     = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q     <= req_action;
			cls_req_q <= req_size_class;
			present_q <= req_handle_present;
			handle_q  <= req_handle;
		end
		if (cmd.execute) begin
			status_q  <= status_nxt;
			granted_q <= granted_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG_REGS; i++) begin
				cnt_q[i] <= SLOTS_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLOTS_CLASS0: cnt_q[0] <= cfg_data;
				CFG_SLOTS_CLASS1: cnt_q[1] <= cfg_data;
				CFG_SLOTS_CLASS2: cnt_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				map_q[i] <= '0;
			end
		end else if (cmd.execute && map_we) begin
			map_q[addr] <= map_nxt;
		end
	end

	assign res_status         = status_q;
	assign res_granted_handle = granted_q;

endmodule
